// File: rtl/core/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window median filter
// Register width, reset value and the per-cell control group.
// ---------------------------------------------------------------------------
package swm_pkg;

	// Width and reset value of the half window register.
	localparam int HALF_BITS = 6;
	localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(8);

	// Control bits that every cell of the sorted window receives.
	typedef struct packed {
		logic step;    // a transaction is accepted in this cycle
		logic clr;     // the window is refilled with zeros before the sample enters
		logic refill;  // configuration write: reload the cell with its reset contents
		logic live;    // the cell lies inside the current window
		logic last;    // the cell is the top slot of the current window
	} cell_ctl_t;

endpackage

// File: rtl/core/swm_in_if.sv
// ---------------------------------------------------------------------------
// swm_in_if: sample input channel
// Valid/ready channel carrying one sample and its clear flag.
// ---------------------------------------------------------------------------
interface swm_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   clear;

	modport source (output valid, output sample, output clear, input ready);
	modport sink   (input valid, input sample, input clear, output ready);
endinterface

// File: rtl/core/swm_out_if.sv
// ---------------------------------------------------------------------------
// swm_out_if: median result channel
// Valid/ready channel carrying one median value.
// ---------------------------------------------------------------------------
interface swm_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink   (input valid, input median, output ready);
endinterface

// File: rtl/core/swm_cell.sv
// ---------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds a value and its age rank; drops the oldest and inserts the new
// sample using only its own contents and those of its two neighbours.
// ---------------------------------------------------------------------------
module swm_cell
	import swm_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int AGE_BITS    = 6,
	parameter int IDX         = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_ctl_t              ctl,
	input  logic [SAMPLE_BITS-1:0] x,
	input  logic [AGE_BITS-1:0]    top_age,
	input  logic                   rm,
	input  logic [SAMPLE_BITS-1:0] up_v,
	input  logic [AGE_BITS-1:0]    up_a,
	input  logic [SAMPLE_BITS-1:0] dn_v,
	input  logic [AGE_BITS-1:0]    dn_a,
	input  logic                   dn_gt,
	output logic [SAMPLE_BITS-1:0] cur_v,
	output logic [AGE_BITS-1:0]    cur_a,
	output logic [SAMPLE_BITS-1:0] sh_v,
	output logic [AGE_BITS-1:0]    sh_a,
	output logic                   gt,
	output logic [SAMPLE_BITS-1:0] nv
);

	localparam logic [AGE_BITS-1:0] OWN_AGE = AGE_BITS'(IDX);

	logic [SAMPLE_BITS-1:0] v_q;
	logic [AGE_BITS-1:0]    a_q;
	logic [AGE_BITS-1:0]    na;
	logic                   take_dn;

	// Contents as seen by this transaction, with a clear applied.
	assign cur_v = ctl.clr ? '0 : v_q;
	assign cur_a = ctl.clr ? OWN_AGE : a_q;

	// After the oldest slot is dropped, slots at or above it move down one.
	// The age is handed on already decremented.
	assign sh_v = rm ? up_v : cur_v;
	assign sh_a = (rm ? up_a : cur_a) - 1'b1;
	assign gt   = sh_v > x;

	always_comb begin
		take_dn = 1'b0;
		if (ctl.last || gt) begin
			take_dn = dn_gt;
			if (dn_gt) begin
				nv = dn_v;
				na = dn_a;
			end else begin
				nv = x;
				na = top_age;
			end
		end else begin
			nv = sh_v;
			na = sh_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			a_q <= OWN_AGE;
		end else if (ctl.refill) begin
			v_q <= '0;
			a_q <= OWN_AGE;
		end else if (ctl.step && ctl.live) begin
			v_q <= nv;
			a_q <= na;
		end
	end

	// A slot taken from below never skips a cell whose own value fits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && ctl.live && take_dn) |-> (dn_v > x))
		else $error("swm_cell: shifted a value that is not greater than the sample");

endmodule

// File: rtl/core/sliding_window_median.sv
// ---------------------------------------------------------------------------
// sliding_window_median: running upper median over a sorted sample window
// A row of compare-and-shift cells keeps the last 2*H samples sorted and
// returns the element at sorted position H for every sample.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload                    Transaction
//  samples   in         sample, clear              valid && ready
//  medians   out        median                     valid && ready
//  cfg       in         cfg_wr_data (half window)  cfg_wr_en
//
// One sample is taken per clock cycle unless a result is stalled. Every cell
// of the row updates in the same cycle from its own contents and its
// neighbours', so the rate is set by one pass through the row of cells;
// the median is written to the output register as the sample is accepted.
// The reset of arst_n fills the window with zeros at once; a write to the
// half window register does the same at the next clock edge.
// A stalled result holds the output register; a new sample is taken in the
// cycle that the waiting result leaves, so the row never idles behind it.
//
module sliding_window_median
	import swm_pkg::*;
#(
	parameter int MAX_HALF    = 32,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	swm_in_if.sink               samples,
	swm_out_if.source            medians,
	input  logic                 cfg_wr_en,
	input  logic [HALF_BITS-1:0] cfg_wr_data
);

	localparam int DEPTH    = 2 * MAX_HALF;
	localparam int AGE_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HB       = $clog2(MAX_HALF + 1);
	localparam int LEVELS   = AGE_BITS;

	// Configuration register and the clamped half window derived from it.
	logic [HALF_BITS-1:0] half_cfg_q;
	logic [HB-1:0]        half_eff;
	logic [AGE_BITS-1:0]  top_age;

	// Output register.
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] median_q;

	logic step;

	// Per-cell wiring of the row.
	cell_ctl_t              ctl   [DEPTH];
	logic [SAMPLE_BITS-1:0] cur_v [DEPTH];
	logic [AGE_BITS-1:0]    cur_a [DEPTH];
	logic [SAMPLE_BITS-1:0] sh_v  [DEPTH];
	logic [AGE_BITS-1:0]    sh_a  [DEPTH];
	logic [SAMPLE_BITS-1:0] nv    [DEPTH];
	logic [DEPTH-1:0]       gt;
	logic [DEPTH-1:0]       is_old;
	logic [DEPTH-1:0]       live;
	logic [DEPTH-1:0]       rm;
	logic [DEPTH-1:0]       pfx [LEVELS+1];
	logic                   sorted_ok;

	// The half window is taken as 1 when zero and saturates at MAX_HALF.
	always_comb begin
		if (half_cfg_q == '0) begin
			half_eff = HB'(1);
		end else if (int'(half_cfg_q) > MAX_HALF) begin
			half_eff = HB'(MAX_HALF);
		end else begin
			half_eff = HB'(half_cfg_q);
		end
		top_age = AGE_BITS'(2 * int'(half_eff) - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_cfg_q <= HALF_RESET;
		end else if (cfg_wr_en) begin
			half_cfg_q <= cfg_wr_data;
		end
	end

	// A new sample is taken whenever the output register is free or is
	// being emptied in this cycle.
	assign samples.ready = !out_valid_q || medians.ready;
	assign step          = samples.valid && samples.ready;

	// Exactly one slot holds the oldest sample. Every slot at or above it
	// shifts down, which is a prefix OR of the oldest markers, built as a
	// log-depth network.
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			is_old[k] = (cur_a[k] == '0);
		end
		pfx[0] = is_old;
		for (int l = 0; l < LEVELS; l++) begin
			for (int k = 0; k < DEPTH; k++) begin
				if (k >= (1 << l)) begin
					pfx[l+1][k] = pfx[l][k] | pfx[l][k - (1 << l)];
				end else begin
					pfx[l+1][k] = pfx[l][k];
				end
			end
		end
		rm = pfx[LEVELS];
	end

	// Control of each cell: whether it lies in the window and whether it
	// is the top slot, where the new sample lands when nothing is greater.
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			live[k]       = k < 2 * int'(half_eff);
			ctl[k].step   = step;
			ctl[k].clr    = samples.clear;
			ctl[k].refill = cfg_wr_en;
			ctl[k].live   = live[k];
			ctl[k].last   = k == 2 * int'(half_eff) - 1;
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [SAMPLE_BITS-1:0] up_v;
		logic [AGE_BITS-1:0]    up_a;
		logic [SAMPLE_BITS-1:0] dn_v;
		logic [AGE_BITS-1:0]    dn_a;
		logic                   dn_gt;

		if (k == DEPTH - 1) begin : g_top
			assign up_v = '0;
			assign up_a = '0;
		end else begin : g_up
			assign up_v = cur_v[k+1];
			assign up_a = cur_a[k+1];
		end

		if (k == 0) begin : g_bottom
			assign dn_v  = '0;
			assign dn_a  = '0;
			assign dn_gt = 1'b0;
		end else begin : g_dn
			assign dn_v  = sh_v[k-1];
			assign dn_a  = sh_a[k-1];
			assign dn_gt = gt[k-1];
		end

		swm_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.AGE_BITS    (AGE_BITS),
			.IDX         (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[k]),
			.x       (samples.sample),
			.top_age (top_age),
			.rm      (rm[k]),
			.up_v    (up_v),
			.up_a    (up_a),
			.dn_v    (dn_v),
			.dn_a    (dn_a),
			.dn_gt   (dn_gt),
			.cur_v   (cur_v[k]),
			.cur_a   (cur_a[k]),
			.sh_v    (sh_v[k]),
			.sh_a    (sh_a[k]),
			.gt      (gt[k]),
			.nv      (nv[k])
		);
	end

	// The upper median is the new content of slot H.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (medians.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			median_q <= nv[AGE_BITS'(half_eff)];
		end
	end

	assign medians.valid  = out_valid_q;
	assign medians.median = median_q;

	// The live part of the window stays in ascending order.
	always_comb begin
		sorted_ok = 1'b1;
		for (int k = 0; k + 1 < DEPTH; k++) begin
			if (live[k+1] && (cur_v[k] > cur_v[k+1])) begin
				sorted_ok = 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(is_old & live))
		else $error("sliding_window_median: window must hold exactly one oldest sample");

	assert property (@(posedge clk) disable iff (!arst_n)
		step |-> sorted_ok)
		else $error("sliding_window_median: window lost its sorted order");

	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> medians.valid)
		else $error("sliding_window_median: accepted sample produced no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !medians.ready) |-> !step)
		else $error("sliding_window_median: sample taken while a result is stalled");

endmodule
